[design/prq_pkg.sv]
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int OCC_W   = 5;
    localparam int TASK_W  = ID_W + PRIO_W + BURST_W;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // fields listed from the high bit down
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id;
    } t_task;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_POP,
        S_DONE
    } t_state;

endpackage

[design/prq_ram.sv]
// ----------------------------------------------------------------------------
// prq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/priority_ready_queue_pinned_head.sv]
// ----------------------------------------------------------------------------
// priority_ready_queue_pinned_head
// Ready queue with a pinned running task at the head and sorted insertion.
// A push to an empty or full queue goes straight to the report; any other push
// reads the entry ahead of it, then compares and moves past it while it wins,
// until it stops or lands right behind the head; a pop holding two or more tasks
// goes through the pop step first. One word in flight; the next is taken in the
// cycle after the report loads, and an untaken report stalls the final step. Head task in flops, rest in RAM.
// Reset (sync, active low) empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module priority_ready_queue_pinned_head #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // task_id[7:0], task_priority[15:8], burst_time[31:16]
    input  logic [prq_pkg::S_DATA_W-1:0]  i_s_tdata,
    // command[0]
    input  logic [prq_pkg::S_USER_W-1:0]  i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // head_id[7:0], head_priority[15:8], head_burst[31:16], occupancy[36:32]
    output logic [prq_pkg::M_DATA_W-1:0]  o_m_tdata,
    // head_valid[0], dropped[1]
    output logic [prq_pkg::M_USER_W-1:0]  o_m_tuser
);

    import prq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_state          r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_base, n_base;
    logic [AW-1:0]   r_pos, n_pos;
    t_task           r_new, n_new;
    t_task           r_head, n_head;
    logic            r_drop, n_drop;
    logic            r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;
    logic [M_USER_W-1:0] r_out_user, n_out_user;

    logic            s_accept;
    logic            out_load;
    t_task           in_task;
    t_task           rd_task;
    logic            beats;

    logic            ram_we;
    logic [AW-1:0]   wr_j, rd_j;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [AW:0]     wr_sum, rd_sum;
    t_task           wr_task;
    logic [TASK_W-1:0] ram_rdata;

    assign in_task.id    = i_s_tdata[ID_W-1:0];
    assign in_task.prio  = i_s_tdata[ID_W+PRIO_W-1:ID_W];
    assign in_task.burst = i_s_tdata[TASK_W-1:ID_W+PRIO_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign rd_task = t_task'(ram_rdata);
    assign beats   = (r_new.prio > rd_task.prio) ||
                     ((r_new.prio == rd_task.prio) && (r_new.burst < rd_task.burst));

    // logical buffer index to physical address, wrapping at the depth
    assign wr_sum  = {1'b0, r_base} + {1'b0, wr_j};
    assign rd_sum  = {1'b0, r_base} + {1'b0, rd_j};
    assign wr_addr = (wr_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                     AW'(wr_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(wr_sum);
    assign rd_addr = (rd_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                     AW'(rd_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(rd_sum);

    prq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (wr_task),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser[0] == CMD_PUSH) begin
                        if (r_fill == FW'(QUEUE_DEPTH) || r_fill == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_READ;
                        end
                    end else begin
                        if (r_fill > FW'(1)) begin
                            n_state = S_POP;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_READ:  n_state = (r_pos == '0) ? S_DONE : S_CMP;
            S_CMP:   n_state = beats ? S_READ : S_DONE;
            S_POP:   n_state = S_DONE;
            S_DONE:  n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_fill      = r_fill;
        n_base      = r_base;
        n_pos       = r_pos;
        n_new       = r_new;
        n_head      = r_head;
        n_drop      = r_drop;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        wr_j        = r_pos;
        rd_j        = r_pos - AW'(1);
        wr_task     = r_new;

        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_new  = in_task;
                    n_drop = 1'b0;
                    n_pos  = AW'(r_fill - FW'(1));
                    if (i_s_tuser[0] == CMD_PUSH) begin
                        if (r_fill == FW'(QUEUE_DEPTH)) begin
                            n_drop = 1'b1;
                        end else if (r_fill == '0) begin
                            n_head = in_task;
                            n_fill = FW'(1);
                        end
                    end else begin
                        rd_j = '0;
                        if (r_fill == FW'(1)) begin
                            n_fill = '0;
                        end
                    end
                end
            end
            S_READ: begin
                if (r_pos == '0) begin
                    ram_we = 1'b1;
                    n_fill = r_fill + FW'(1);
                end
            end
            S_CMP: begin
                ram_we = 1'b1;
                if (beats) begin
                    wr_task = rd_task;
                    n_pos   = r_pos - AW'(1);
                end else begin
                    n_fill = r_fill + FW'(1);
                end
            end
            S_POP: begin
                n_head = rd_task;
                n_base = (r_base == AW'(QUEUE_DEPTH - 1)) ? '0 : r_base + AW'(1);
                n_fill = r_fill - FW'(1);
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_user  = {r_drop, (r_fill != '0)};
                    n_out_data  = {3'b000, OCC_W'(r_fill),
                                   (r_fill != '0) ? r_head : t_task'('0)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_new      <= n_new;
        r_head     <= n_head;
        r_drop     <= n_drop;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tdata[36:32] == OCC_W'(QUEUE_DEPTH))
        else $error("drop reported on a queue that is not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0)
        else $error("empty result carries nonzero fields");

    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |-> r_pos != '0 && $past(r_state) == S_READ)
        else $error("compare step without a pending read");

endmodule
